/* src/positional_insert_delete_list_assert.svh */
// assertion macros for the positional insert/delete list
// depends on nothing; included by the top level
`ifndef POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PIDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PIDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PIDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PIDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/pidl_pkg.sv */
// shared types and codes for the positional insert/delete list
// depends on nothing
`default_nettype none
package pidl_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 16;
    // cell index width, wide enough for a depth of up to 64
    localparam int CIDX_W    = 6;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [2:0] FN_INS_END   = 3'd0;
    localparam logic [2:0] FN_INS_FRONT = 3'd1;
    localparam logic [2:0] FN_INS_AT    = 3'd2;
    localparam logic [2:0] FN_DEL_END   = 3'd3;
    localparam logic [2:0] FN_DEL_FRONT = 3'd4;
    localparam logic [2:0] FN_DEL_AT    = 3'd5;
    localparam logic [2:0] FN_DUMP      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [2:0]               func;
        logic [4:0]               position;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]               status;
        logic [4:0]               count;
        logic [3:0]               index;
        logic signed [WORD_W-1:0] entry;
        logic                     last;
    } t_res;

    // control broadcast to every cell
    typedef struct packed {
        logic              up;      // cells above pos take left neighbor
        logic              down;    // cells at or above pos take right neighbor
        logic              wr;      // cell at wr_idx takes the broadcast word
        logic [CIDX_W-1:0] pos;
        logic [CIDX_W-1:0] wr_idx;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* src/positional_insert_delete_list.sv */
// top level of the positional insert/delete list: control and cell chain
// depends on pidl_pkg, pidl_cell and positional_insert_delete_list_assert.svh
//
// Insert and delete words are taken one per clock: busy stays low, cells from
// the target place up shift by one place in the same cycle, and the single
// result shows on o_result with o_strobe in the cycle after start. A dump of n
// entries (n > 0) holds busy high while the row rotates past cell 0, and
// streams n results on consecutive cycles via the state and result registers,
// the final one marked last; the rotation leaves the list in its original
// order. A dump of an empty list gives one result in the cycle after start.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
`include "positional_insert_delete_list_assert.svh"
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire pidl_pkg::t_cmd i_cmd,
    output pidl_pkg::t_res    o_result,
    output logic              o_strobe,
    input  wire               i_cfg_we,
    input  wire logic [4:0]   i_cfg_wdata
);
    import pidl_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [4:0]        r_cap, n_cap;
    logic [IW-1:0]     r_k, n_k;
    logic              r_strobe, n_strobe;
    t_res              r_result, n_result;

    t_cell_ctl                cell_ctl;
    logic signed [WORD_W-1:0] wr_word;
    logic signed [WORD_W-1:0] w_word [DEPTH];

    logic [CMPW-1:0] used_x, pos_x, cap_x, cap_eff, last_x;
    logic [CMPW-1:0] ins_pos, del_pos;
    logic            accept;

    // operand preparation
    assign accept  = start && (r_state == S_IDLE);
    assign used_x  = CMPW'(r_used);
    assign pos_x   = CMPW'(i_cmd.position);
    assign cap_x   = CMPW'(r_cap);
    assign cap_eff = (cap_x < DEPTH_C) ? cap_x : DEPTH_C;
    assign last_x  = used_x - CMPW'(1);

    // target place of an insert or delete
    always_comb begin
        case (i_cmd.func)
            FN_INS_END:   ins_pos = used_x;
            FN_INS_FRONT: ins_pos = '0;
            default:      ins_pos = pos_x;
        endcase
        case (i_cmd.func)
            FN_DEL_END:   del_pos = last_x;
            FN_DEL_FRONT: del_pos = '0;
            default:      del_pos = pos_x;
        endcase
    end

    // next state, cell control and result word
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_cap    = i_cfg_we ? i_cfg_wdata : r_cap;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_result = r_result;
        cell_ctl = '0;
        wr_word  = i_cmd.value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_strobe        = 1'b1;
                    n_result.status = ST_OK;
                    n_result.index  = '0;
                    n_result.entry  = '0;
                    n_result.last   = 1'b1;
                    case (i_cmd.func)
                        FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
                            if (used_x >= cap_eff) begin
                                n_result.status = ST_FULL;
                            end else if (ins_pos > used_x) begin
                                n_result.status = ST_BAD;
                            end else begin
                                cell_ctl.up     = 1'b1;
                                cell_ctl.wr     = 1'b1;
                                cell_ctl.pos    = CIDX_W'(ins_pos);
                                cell_ctl.wr_idx = CIDX_W'(ins_pos);
                                n_used          = CW'(used_x + CMPW'(1));
                            end
                        end
                        FN_DEL_END, FN_DEL_FRONT, FN_DEL_AT: begin
                            if (r_used == '0) begin
                                n_result.status = ST_EMPTY;
                            end else if (del_pos >= used_x) begin
                                n_result.status = ST_BAD;
                            end else begin
                                cell_ctl.down = 1'b1;
                                cell_ctl.pos  = CIDX_W'(del_pos);
                                n_used        = CW'(last_x);
                            end
                        end
                        FN_DUMP: begin
                            if (r_used == '0) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_strobe = 1'b0;
                                n_state  = S_DUMP;
                                n_k      = '0;
                            end
                        end
                        default: begin
                            n_result.status = ST_OK;
                        end
                    endcase
                    n_result.count = 5'(n_used);
                end
            end
            S_DUMP: begin
                // rotate the occupied cells down by one, head goes to the top
                wr_word         = w_word[0];
                cell_ctl.down   = 1'b1;
                cell_ctl.wr     = 1'b1;
                cell_ctl.pos    = '0;
                cell_ctl.wr_idx = CIDX_W'(last_x);
                n_strobe        = 1'b1;
                n_result.status = ST_OK;
                n_result.count  = 5'(r_used);
                n_result.index  = 4'(r_k);
                n_result.entry  = w_word[0];
                n_result.last   = (r_k == IW'(last_x));
                if (r_k == IW'(last_x)) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cap    <= CAP_RESET;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cap    <= n_cap;
            r_k      <= n_k;
            r_strobe <= n_strobe;
        end
        r_result <= n_result;
    end

    assign busy     = (r_state == S_DUMP);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] left_w, right_w;
        if (g == 0) begin : g_lo
            assign left_w = '0;
        end else begin : g_lo
            assign left_w = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign right_w = '0;
        end else begin : g_hi
            assign right_w = w_word[g+1];
        end
        pidl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_wr_word (wr_word),
            .i_left    (left_w),
            .i_right   (right_w),
            .o_word    (w_word[g])
        );
    end

    // checks
    `PIDL_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, (used_x <= DEPTH_C), "count beyond depth")
    `PIDL_ASSERT_IMP(a_dump_nonempty, i_clk, i_rst_n, busy, (r_used != '0), "dump of empty list")
    `PIDL_ASSERT_NXT(a_single_result, i_clk, i_rst_n, (accept && (i_cmd.func != FN_DUMP)), (o_strobe && o_result.last), "missing result")
    `PIDL_ASSERT_NXT(a_used_hold, i_clk, i_rst_n, !accept, $stable(r_used), "count changed without item")

endmodule
`default_nettype wire

/* src/pidl_cell.sv */
// one storage cell of the list chain
// depends on pidl_pkg
`default_nettype none
module pidl_cell #(
    parameter int IDX = 0
) (
    input  wire                                  i_clk,
    input  wire pidl_pkg::t_cell_ctl             i_ctl,
    input  wire logic signed [pidl_pkg::WORD_W-1:0] i_wr_word,
    input  wire logic signed [pidl_pkg::WORD_W-1:0] i_left,
    input  wire logic signed [pidl_pkg::WORD_W-1:0] i_right,
    output logic signed [pidl_pkg::WORD_W-1:0]     o_word
);
    import pidl_pkg::*;

    localparam logic [CIDX_W-1:0] MY_IDX = CIDX_W'(IDX);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    // pick write, shift up, shift down or hold
    always_comb begin
        n_word = r_word;
        if (i_ctl.wr && (MY_IDX == i_ctl.wr_idx)) begin
            n_word = i_wr_word;
        end else if (i_ctl.up && (MY_IDX > i_ctl.pos)) begin
            n_word = i_left;
        end else if (i_ctl.down && (MY_IDX >= i_ctl.pos)) begin
            n_word = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

/* test/pidl_list_monitor.sv */
// monitor for the positional insert/delete list: predicts and compares every result word
// depends on pidl_pkg; instantiated beside the block by tb_positional_insert_delete_list
module pidl_list_monitor (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire            i_busy,
    input  pidl_pkg::t_cmd i_cmd,
    input  pidl_pkg::t_res i_result,
    input  wire            i_strobe,
    input  wire            i_cfg_we,
    input  wire [4:0]      i_cfg_wdata,
    output int             o_pending,
    output int             o_fail_count
);
    import pidl_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // private copy of the list and its capacity register
    logic signed [WORD_W-1:0] list_words [DEPTH];
    int                       list_used;
    logic [4:0]               capacity_reg;

    // result words still owed by the block, oldest first
    t_res due_results [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    // apply one command word to the private list and queue the results it owes
    task automatic predict_list_op(input t_cmd c);
        logic [1:0] st;
        int         pos;
        int         lim;
        int         i;
        t_res       r;
        st  = ST_OK;
        lim = (capacity_reg < DEPTH) ? int'(capacity_reg) : DEPTH;
        r   = '0;
        case (c.func)
            FN_INS_END, FN_INS_FRONT, FN_INS_AT: begin
                if (c.func == FN_INS_END)
                    pos = list_used;
                else if (c.func == FN_INS_FRONT)
                    pos = 0;
                else
                    pos = int'(c.position);
                // full wins over a bad position
                if (list_used >= lim) begin
                    st = ST_FULL;
                end else if (pos > list_used) begin
                    st = ST_BAD;
                end else begin
                    for (i = list_used; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = c.value;
                    list_used++;
                end
            end
            FN_DEL_END, FN_DEL_FRONT, FN_DEL_AT: begin
                if (c.func == FN_DEL_END)
                    pos = list_used - 1;
                else if (c.func == FN_DEL_FRONT)
                    pos = 0;
                else
                    pos = int'(c.position);
                // empty wins over a bad position
                if (list_used == 0) begin
                    st = ST_EMPTY;
                end else if (pos >= list_used) begin
                    st = ST_BAD;
                end else begin
                    for (i = pos; i + 1 < list_used; i++)
                        list_words[i] = list_words[i+1];
                    list_used--;
                end
            end
            FN_DUMP: begin
                if (list_used == 0)
                    st = ST_EMPTY;
            end
            default: st = ST_OK;
        endcase
        if (c.func == FN_DUMP && list_used > 0) begin
            // one word per entry, in order, last one marked
            for (i = 0; i < list_used; i++) begin
                r.status = ST_OK;
                r.count  = list_used[4:0];
                r.index  = i[3:0];
                r.entry  = list_words[i];
                r.last   = (i + 1 == list_used);
                due_results.push_back(r);
            end
        end else begin
            r.status = st;
            r.count  = list_used[4:0];
            r.last   = 1'b1;
            due_results.push_back(r);
        end
    endtask

    // compare result words, track configuration, then predict new commands
    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            list_used    = 0;
            capacity_reg = CAP_RESET;
            due_results.delete();
        end else begin
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word: status %0d count %0d index %0d entry %0d last %0d",
                             $time, i_result.status, i_result.count, i_result.index,
                             i_result.entry, i_result.last);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_result.status);
                        o_fail_count++;
                    end
                    if (i_result.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, i_result.count);
                        o_fail_count++;
                    end
                    if (i_result.index !== want.index) begin
                        $display("%0t: index expected %0d actual %0d",
                                 $time, want.index, i_result.index);
                        o_fail_count++;
                    end
                    if (i_result.entry !== want.entry) begin
                        $display("%0t: entry expected %0d actual %0d",
                                 $time, want.entry, i_result.entry);
                        o_fail_count++;
                    end
                    if (i_result.last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, i_result.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we)
                capacity_reg = i_cfg_wdata;
            if (i_start && !i_busy)
                predict_list_op(i_cmd);
        end
        o_pending <= due_results.size();
    end

endmodule

/* test/tb_positional_insert_delete_list.sv */
// testbench top for the positional insert/delete list: clock, reset, stimulus and verdict
// depends on pidl_pkg, positional_insert_delete_list and pidl_list_monitor
module tb_positional_insert_delete_list;
    import pidl_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SEGMENTS    = 6;
    localparam int SEG_WORDS   = 35;
    localparam logic [2:0] FN_SPARE = 3'd7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    t_cmd       cmd       = '0;
    logic       cfg_we    = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic       busy;
    t_res       result;
    logic       strobe;
    int         pending;
    int         fail_count;
    int         stall_cycles = 0;
    int         idle_pct = 0;

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    positional_insert_delete_list i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_result    (result),
        .o_strobe    (strobe),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    pidl_list_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_result     (result),
        .i_strobe     (strobe),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog: cycles with no command or result word moving
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("positional_insert_delete_list test failed");
        $finish;
    end

    function automatic t_cmd make_cmd(input logic [2:0] f, input logic [4:0] p,
                                      input logic [31:0] v);
        t_cmd c;
        c.func     = f;
        c.position = p;
        c.value    = v;
        return c;
    endfunction

    // random command; ins_pct steers toward filling or draining the list
    function automatic t_cmd random_cmd(input int ins_pct);
        t_cmd c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.func = FN_DUMP;
        else if (pick < 10)
            c.func = FN_SPARE;
        else if (pick < 10 + ins_pct)
            c.func = 3'($urandom_range(0, 2));
        else
            c.func = 3'($urandom_range(3, 5));
        if ($urandom_range(0, 99) < 85)
            c.position = 5'($urandom_range(0, 16));
        else
            c.position = 5'($urandom_range(0, 31));
        c.value = $urandom;
        return c;
    endfunction

    // present one command word and hold it until the block takes it
    task automatic send_cmd(input t_cmd c);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait for every owed result word, then let the block settle
    task automatic drain(input int settle);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        drain(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int seg_cap [SEGMENTS];
        int seg;
        int n;
        int sent;
        seg_cap = '{16, 5, 31, 1, 0, 16};
        seg_cap[4] = $urandom_range(2, 15);
        sent = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corner cases at reset capacity
        idle_pct = 20;
        send_cmd(make_cmd(FN_DUMP, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_DEL_END, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_DEL_FRONT, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_DEL_AT, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_SPARE, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_INS_AT, 5'd1, 32'd5));
        // value extremes and inserts at every place
        send_cmd(make_cmd(FN_INS_END, 5'd0, 32'h7fff_ffff));
        send_cmd(make_cmd(FN_INS_FRONT, 5'd0, 32'h8000_0000));
        send_cmd(make_cmd(FN_INS_AT, 5'd31, 32'd9));
        send_cmd(make_cmd(FN_INS_AT, 5'd2, 32'hffff_ffff));
        send_cmd(make_cmd(FN_INS_AT, 5'd1, 32'd0));
        send_cmd(make_cmd(FN_DUMP, 5'd0, 32'd0));
        // delete position bounds
        send_cmd(make_cmd(FN_DEL_AT, 5'd4, 32'd0));
        send_cmd(make_cmd(FN_DEL_AT, 5'd31, 32'd0));
        send_cmd(make_cmd(FN_DEL_AT, 5'd1, 32'd0));
        send_cmd(make_cmd(FN_SPARE, 5'd31, 32'hffff_ffff));
        // capacity lowered below the current count
        write_capacity(5'd1);
        send_cmd(make_cmd(FN_INS_FRONT, 5'd0, 32'd3));
        send_cmd(make_cmd(FN_DEL_END, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_DEL_FRONT, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_DUMP, 5'd0, 32'd0));
        // zero capacity: every insert is full
        write_capacity(5'd0);
        send_cmd(make_cmd(FN_INS_END, 5'd0, 32'd1));
        send_cmd(make_cmd(FN_DEL_AT, 5'd0, 32'd0));
        send_cmd(make_cmd(FN_INS_FRONT, 5'd0, 32'd2));
        // capacity above the depth
        write_capacity(5'd31);
        send_cmd(make_cmd(FN_INS_END, 5'd0, 32'h1234_5678));
        send_cmd(make_cmd(FN_DUMP, 5'd0, 32'd0));

        // random segments: sender idles 20, then 80, then never
        for (seg = 0; seg < SEGMENTS; seg++) begin
            write_capacity(5'(seg_cap[seg]));
            idle_pct = (seg < 2) ? 20 : (seg < 4) ? 80 : 0;
            for (n = 0; n < SEG_WORDS; n++) begin
                send_cmd(random_cmd(((sent / 32) % 2) ? 20 : 70));
                sent++;
                if ($urandom_range(0, 99) < 2)
                    drain(0);
            end
        end

        drain(20);
        if (fail_count == 0)
            $display("positional_insert_delete_list test passed");
        else
            $display("positional_insert_delete_list test failed");
        $finish;
    end

endmodule

/* positional_insert_delete_list.f */
+incdir+src
src/pidl_pkg.sv
src/pidl_cell.sv
src/positional_insert_delete_list.sv
test/pidl_list_monitor.sv
test/tb_positional_insert_delete_list.sv
